// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/aaf_pkg.sv =====
`default_nettype none

package aaf_pkg;

    // Function codes carried by the func field.
    typedef enum logic [3:0] {
        FN_ADD = 4'd0,
        FN_ADC = 4'd1,
        FN_SUB = 4'd2,
        FN_SBB = 4'd3,
        FN_AND = 4'd4,
        FN_XOR = 4'd5,
        FN_OR  = 4'd6,
        FN_CMP = 4'd7,
        FN_RLC = 4'd8,
        FN_RRC = 4'd9,
        FN_RAL = 4'd10,
        FN_RAR = 4'd11,
        FN_DAA = 4'd12,
        FN_CMA = 4'd13,
        FN_STC = 4'd14,
        FN_CMC = 4'd15
    } func_t;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
    localparam logic [3:0] DAA_DIGIT_MAX = 4'd9;

    typedef struct packed {
        logic carry;
        logic zero;
        logic sign;
        logic parity;
    } flags_t;

    // Architectural state: accumulator and flags.
    typedef struct packed {
        logic [7:0] acc;
        flags_t     flags;
    } alu_state_t;

    // One registered instruction waiting for the ALU.
    typedef struct packed {
        func_t      func;
        logic [7:0] operand;
    } issue_t;

    // Zero, sign and parity of a result byte, carry left clear.
    function automatic flags_t zsp_flags(input logic [7:0] value);
        flags_t f;
        f.carry  = 1'b0;
        f.zero   = (value == 8'h00);
        f.sign   = value[7];
        f.parity = ~^value;
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/aaf_in_stage.sv =====
`default_nettype none

module aaf_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire logic [3:0]      func,
    input  wire logic [7:0]      operand,
    input  wire logic            take,
    output logic                 stage_valid,
    output aaf_pkg::issue_t      stage_issue
);

    logic            valid_reg;
    logic            valid_next;
    aaf_pkg::issue_t issue_reg;
    logic            load;

    // The stage frees up whenever its item moves on in the same cycle.
    assign item_ready = !valid_reg || take;
    assign load       = item_valid && item_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= '0;
        end
        else if (load)
        begin
            issue_reg.func    <= aaf_pkg::func_t'(func);
            issue_reg.operand <= operand;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_issue = issue_reg;

endmodule

`default_nettype wire

// ===== rtl/aaf_alu.sv =====
`default_nettype none

module aaf_alu (
    input  wire aaf_pkg::alu_state_t cur,
    input  wire aaf_pkg::issue_t     op,
    output aaf_pkg::alu_state_t      nxt
);

    logic [7:0] a;
    logic       cin;
    logic [8:0] addend;
    logic [8:0] sum;
    logic [8:0] subtrahend;
    logic [8:0] diff;
    logic [7:0] daa_corr;
    logic [8:0] daa_sum;

    assign a   = cur.acc;
    assign cin = cur.flags.carry;

    // Shared adder for add and add with carry.
    assign addend = {1'b0, op.operand} + ((op.func == aaf_pkg::FN_ADC) ? {8'h00, cin} : 9'h000);
    assign sum    = {1'b0, a} + addend;

    // Shared subtractor for sub, sbb and compare; bit 8 is the borrow.
    assign subtrahend = {1'b0, op.operand}
                      + ((op.func == aaf_pkg::FN_SBB) ? {8'h00, cin} : 9'h000);
    assign diff       = {1'b0, a} - subtrahend;

    // Decimal adjust correction, without auxiliary carry.
    always_comb
    begin
        daa_corr = 8'h00;
        if (a[3:0] > aaf_pkg::DAA_DIGIT_MAX)
        begin
            daa_corr = daa_corr | aaf_pkg::DAA_LOW_ADJ;
        end
        if ((a[7:4] > aaf_pkg::DAA_DIGIT_MAX) || cin)
        begin
            daa_corr = daa_corr | aaf_pkg::DAA_HIGH_ADJ;
        end
    end

    assign daa_sum = {1'b0, a} + {1'b0, daa_corr};

    // Result and flag selection.
    always_comb
    begin
        nxt = cur;
        unique case (op.func) inside
            aaf_pkg::FN_ADD, aaf_pkg::FN_ADC:
            begin
                nxt.acc         = sum[7:0];
                nxt.flags       = aaf_pkg::zsp_flags(sum[7:0]);
                nxt.flags.carry = sum[8];
            end
            aaf_pkg::FN_SUB, aaf_pkg::FN_SBB:
            begin
                nxt.acc         = diff[7:0];
                nxt.flags       = aaf_pkg::zsp_flags(diff[7:0]);
                nxt.flags.carry = diff[8];
            end
            aaf_pkg::FN_CMP:
            begin
                nxt.flags       = aaf_pkg::zsp_flags(diff[7:0]);
                nxt.flags.carry = diff[8];
            end
            aaf_pkg::FN_AND:
            begin
                nxt.acc   = a & op.operand;
                nxt.flags = aaf_pkg::zsp_flags(a & op.operand);
            end
            aaf_pkg::FN_XOR:
            begin
                nxt.acc   = a ^ op.operand;
                nxt.flags = aaf_pkg::zsp_flags(a ^ op.operand);
            end
            aaf_pkg::FN_OR:
            begin
                nxt.acc   = a | op.operand;
                nxt.flags = aaf_pkg::zsp_flags(a | op.operand);
            end
            aaf_pkg::FN_RLC:
            begin
                nxt.acc         = {a[6:0], a[7]};
                nxt.flags.carry = a[7];
            end
            aaf_pkg::FN_RRC:
            begin
                nxt.acc         = {a[0], a[7:1]};
                nxt.flags.carry = a[0];
            end
            aaf_pkg::FN_RAL:
            begin
                nxt.acc         = {a[6:0], cin};
                nxt.flags.carry = a[7];
            end
            aaf_pkg::FN_RAR:
            begin
                nxt.acc         = {cin, a[7:1]};
                nxt.flags.carry = a[0];
            end
            aaf_pkg::FN_DAA:
            begin
                nxt.acc         = daa_sum[7:0];
                nxt.flags       = aaf_pkg::zsp_flags(daa_sum[7:0]);
                nxt.flags.carry = daa_sum[8];
            end
            aaf_pkg::FN_CMA:
            begin
                nxt.acc = ~a;
            end
            aaf_pkg::FN_STC:
            begin
                nxt.flags.carry = 1'b1;
            end
            aaf_pkg::FN_CMC:
            begin
                nxt.flags.carry = ~cin;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/accumulator_alu_with_flags.sv =====
// An input transfer passes through the input register, then through the accumulator/flag
// register that also drives the result ports; a combinational ALU lies between the two.
// Throughput: one item per cycle while result_ready is high; a stalled result holds the flow.
// Reset (rst_n low, asynchronous) clears the accumulator, all flags and both valid bits.
`default_nettype none

module accumulator_alu_with_flags (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic [3:0] func,
    input  wire logic [7:0] operand,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [7:0]      acc_out,
    output logic            carry_out,
    output logic            zero_out,
    output logic            sign_out,
    output logic            parity_out
);

    logic                stage_valid;
    aaf_pkg::issue_t     stage_issue;
    logic                take;
    logic                advance;
    aaf_pkg::alu_state_t state_reg;
    aaf_pkg::alu_state_t state_next;
    logic                result_valid_reg;

    // The result slot can take a new item when empty or when its result transfers now.
    assign take    = !result_valid_reg || result_ready;
    assign advance = stage_valid && take;

    aaf_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .func        (func),
        .operand     (operand),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_issue (stage_issue)
    );

    aaf_alu u_alu (
        .cur (state_reg),
        .op  (stage_issue),
        .nxt (state_next)
    );

    // The architectural state doubles as the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (take)
            begin
                result_valid_reg <= stage_valid;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign acc_out      = state_reg.acc;
    assign carry_out    = state_reg.flags.carry;
    assign zero_out     = state_reg.flags.zero;
    assign sign_out     = state_reg.flags.sign;
    assign parity_out   = state_reg.flags.parity;

endmodule

`default_nettype wire

// ===== rtl/aaf_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module aaf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_ready,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic [7:0] acc_out,
    input wire logic       carry_out,
    input wire logic       zero_out,
    input wire logic       sign_out,
    input wire logic       parity_out
);

    logic [11:0] result_bits;
    logic        result_stall;
    logic        result_xfer;

    // Result payload and handshake views used by the properties below.
    assign result_bits  = {acc_out, carry_out, zero_out, sign_out, parity_out};
    assign result_stall = result_valid && !result_ready;
    assign result_xfer  = result_valid && result_ready;

    // A stalled result keeps its valid and its payload.
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_stall, result_valid && $stable(result_bits))

    // Input back-pressure only appears while a result is stalled.
    `ASSERT_IMPLIES(a_ready_only_stall, clk, rst_n, !item_ready, result_stall)

    // Zero, sign and parity always come from the same byte, so zero implies
    // a clear sign and even parity.
    `ASSERT_IMPLIES(a_zsp_consistent, clk, rst_n, result_valid && zero_out, !sign_out && parity_out)

    // A result that transfers while no input item is offered frees the input side in the next cycle.
    `ASSERT_NEXT(a_drain_frees_input, clk, rst_n, result_xfer && !item_valid, item_ready)

endmodule

bind accumulator_alu_with_flags aaf_checker u_aaf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .acc_out      (acc_out),
    .carry_out    (carry_out),
    .zero_out     (zero_out),
    .sign_out     (sign_out),
    .parity_out   (parity_out)
);

`default_nettype wire

// ===== bench/tb_accumulator_alu_with_flags.sv =====
`timescale 1ns / 1ps

module tb_accumulator_alu_with_flags;

    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_EVERY  = 250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTED  = 40;
    localparam int DIR_ROWS     = 25;

    // Accumulator and flags as the predictor tracks them.
    typedef struct packed {
        logic [7:0] acc;
        logic       cy;
        logic       zf;
        logic       sf;
        logic       pf;
    } acc_flags_t;

    // One directed row: the instruction and, where known by inspection, its result.
    typedef struct packed {
        aaf_pkg::func_t fn;
        logic [7:0]     opd;
        logic           typed;
        acc_flags_t     res;
    } dir_row_t;

    localparam acc_flags_t NO_RES = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0};

    // Directed sequence; results run on from the row above, starting from reset.
    dir_row_t dir_table [0:DIR_ROWS-1] = '{
        '{aaf_pkg::FN_ADD, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{aaf_pkg::FN_ADD, 8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{aaf_pkg::FN_ADD, 8'h01, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b1}},
        '{aaf_pkg::FN_ADC, 8'hFF, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b1}},
        '{aaf_pkg::FN_SUB, 8'h01, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{aaf_pkg::FN_SBB, 8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{aaf_pkg::FN_AND, 8'h0F, 1'b1, '{8'h0F, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{aaf_pkg::FN_XOR, 8'hFF, 1'b1, '{8'hF0, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{aaf_pkg::FN_OR,  8'h01, 1'b1, '{8'hF1, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{aaf_pkg::FN_CMP, 8'hF1, 1'b1, '{8'hF1, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{aaf_pkg::FN_CMP, 8'hFF, 1'b1, '{8'hF1, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{aaf_pkg::FN_RLC, 8'hAA, 1'b0, NO_RES},
        '{aaf_pkg::FN_RRC, 8'h55, 1'b0, NO_RES},
        '{aaf_pkg::FN_RAL, 8'h00, 1'b0, NO_RES},
        '{aaf_pkg::FN_RAR, 8'hFF, 1'b0, NO_RES},
        '{aaf_pkg::FN_CMA, 8'h80, 1'b0, NO_RES},
        '{aaf_pkg::FN_STC, 8'h7F, 1'b0, NO_RES},
        '{aaf_pkg::FN_CMC, 8'h00, 1'b0, NO_RES},
        '{aaf_pkg::FN_CMC, 8'hFF, 1'b0, NO_RES},
        '{aaf_pkg::FN_AND, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{aaf_pkg::FN_OR,  8'h9A, 1'b1, '{8'h9A, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{aaf_pkg::FN_DAA, 8'h00, 1'b0, NO_RES},
        '{aaf_pkg::FN_DAA, 8'hFF, 1'b0, NO_RES},
        '{aaf_pkg::FN_DAA, 8'h00, 1'b0, NO_RES},
        '{aaf_pkg::FN_SBB, 8'h7F, 1'b0, NO_RES}
    };

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic [3:0] func;
    logic [7:0] operand;
    logic       result_valid;
    logic       result_ready;
    logic [7:0] acc_out;
    logic       carry_out;
    logic       zero_out;
    logic       sign_out;
    logic       parity_out;

    acc_flags_t alu_state;
    acc_flags_t pending_results [$];
    int         cycle_count;
    int         error_count;
    int         items_sent;
    int         results_checked;
    int         func_hits [16];

    // Receiver stall pattern state.
    int         ready_mode;
    int         mode_left;
    logic [7:0] ready_mask;
    logic [2:0] ready_phase;

    // Random part bookkeeping.
    int         rand_count;
    int         next_drain;
    int         burst_len;
    int         min_hits;

    accumulator_alu_with_flags dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .operand      (operand),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .acc_out      (acc_out),
        .carry_out    (carry_out),
        .zero_out     (zero_out),
        .sign_out     (sign_out),
        .parity_out   (parity_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Zero, sign and parity from a result byte; carry is left as given.
    function automatic acc_flags_t with_zsp(input acc_flags_t s, input logic [7:0] value);
        acc_flags_t r;
        r     = s;
        r.acc = value;
        r.zf  = (value == 8'h00);
        r.sf  = value[7];
        r.pf  = ~^value;
        return r;
    endfunction

    // Next accumulator and flags after one instruction.
    function automatic acc_flags_t alu_next(input acc_flags_t s, input aaf_pkg::func_t fn,
                                            input logic [7:0] opd);
        acc_flags_t r;
        logic [8:0] wide;
        logic [8:0] subtrahend;
        logic [7:0] fix;
        r          = s;
        subtrahend = {1'b0, opd} + ((fn == aaf_pkg::FN_SBB) ? {8'h00, s.cy} : 9'h000);
        case (fn) inside
            aaf_pkg::FN_ADD, aaf_pkg::FN_ADC:
            begin
                wide = {1'b0, s.acc} + {1'b0, opd}
                     + ((fn == aaf_pkg::FN_ADC) ? {8'h00, s.cy} : 9'h000);
                r    = with_zsp(s, wide[7:0]);
                r.cy = wide[8];
            end
            aaf_pkg::FN_SUB, aaf_pkg::FN_SBB, aaf_pkg::FN_CMP:
            begin
                wide = {1'b0, s.acc} - subtrahend;
                r    = with_zsp(s, wide[7:0]);
                r.cy = ({1'b0, s.acc} < subtrahend);
                if (fn == aaf_pkg::FN_CMP)
                begin
                    r.acc = s.acc;
                end
            end
            aaf_pkg::FN_AND:
            begin
                r    = with_zsp(s, s.acc & opd);
                r.cy = 1'b0;
            end
            aaf_pkg::FN_XOR:
            begin
                r    = with_zsp(s, s.acc ^ opd);
                r.cy = 1'b0;
            end
            aaf_pkg::FN_OR:
            begin
                r    = with_zsp(s, s.acc | opd);
                r.cy = 1'b0;
            end
            aaf_pkg::FN_RLC:
            begin
                r.acc = {s.acc[6:0], s.acc[7]};
                r.cy  = s.acc[7];
            end
            aaf_pkg::FN_RRC:
            begin
                r.acc = {s.acc[0], s.acc[7:1]};
                r.cy  = s.acc[0];
            end
            aaf_pkg::FN_RAL:
            begin
                r.acc = {s.acc[6:0], s.cy};
                r.cy  = s.acc[7];
            end
            aaf_pkg::FN_RAR:
            begin
                r.acc = {s.cy, s.acc[7:1]};
                r.cy  = s.acc[0];
            end
            aaf_pkg::FN_DAA:
            begin
                // No auxiliary carry: only the nibble values and the carry decide.
                fix = 8'h00;
                if (s.acc[3:0] > 4'd9)
                begin
                    fix = fix + 8'h06;
                end
                if ((s.acc[7:4] > 4'd9) || s.cy)
                begin
                    fix = fix + 8'h60;
                end
                wide = {1'b0, s.acc} + {1'b0, fix};
                r    = with_zsp(s, wide[7:0]);
                r.cy = wide[8];
            end
            aaf_pkg::FN_CMA:
            begin
                r.acc = ~s.acc;
            end
            aaf_pkg::FN_STC:
            begin
                r.cy = 1'b1;
            end
            default:
            begin
                r.cy = ~s.cy;
            end
        endcase
        return r;
    endfunction

    // Operand with a bias toward the byte extremes.
    function automatic logic [7:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("ERROR cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Offer one instruction and hold it until the transfer happens.
    task automatic push_item(input aaf_pkg::func_t fn, input logic [7:0] opd,
                             input logic typed, input acc_flags_t typed_res);
        acc_flags_t nxt;
        item_valid <= 1'b1;
        func       <= fn;
        operand    <= opd;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        nxt       = alu_next(alu_state, fn, opd);
        alu_state = nxt;
        pending_results.push_back(typed ? typed_res : nxt);
        items_sent++;
        func_hits[fn]++;
    endtask

    // Sender gap with noise on the payload while valid is low.
    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            item_valid <= 1'b0;
            func       <= 4'($urandom);
            operand    <= 8'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    // Result monitor and receiver stall pattern.
    always @(posedge clk)
    begin
        acc_flags_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result acc=%02h with no transfer pending", acc_out));
            end
            else
            begin
                want = pending_results.pop_front();
                if (acc_out !== want.acc)
                    report_mismatch($sformatf("acc %02h, want %02h", acc_out, want.acc));
                if (carry_out !== want.cy)
                    report_mismatch($sformatf("carry %b, want %b", carry_out, want.cy));
                if (zero_out !== want.zf)
                    report_mismatch($sformatf("zero %b, want %b", zero_out, want.zf));
                if (sign_out !== want.sf)
                    report_mismatch($sformatf("sign %b, want %b", sign_out, want.sf));
                if (parity_out !== want.pf)
                    report_mismatch($sformatf("parity %b, want %b", parity_out, want.pf));
            end
        end

        if (mode_left == 0)
        begin
            ready_mode <= $urandom_range(0, 2);
            ready_mask <= 8'($urandom);
            mode_left  <= $urandom_range(20, 120);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        ready_phase <= ready_phase + 3'd1;
        case (ready_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= ready_mask[ready_phase];
            default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        func            = 4'h0;
        operand         = 8'h00;
        result_ready    = 1'b0;
        ready_mode      = 0;
        mode_left       = 0;
        ready_mask      = 8'hFF;
        ready_phase     = 3'd0;
        cycle_count     = 0;
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        alu_state       = '0;
        foreach (func_hits[i])
        begin
            func_hits[i] = 0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, every function, decimal adjust corner cases.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            push_item(dir_table[i].fn, dir_table[i].opd, dir_table[i].typed, dir_table[i].res);
            idle_cycles($urandom_range(0, 1) * $urandom_range(1, 3));
        end
        wait_drained();

        // Random bursts; some are BCD additions followed by a decimal adjust.
        rand_count = 0;
        next_drain = DRAIN_EVERY;
        while (rand_count < RANDOM_ITEMS)
        begin
            burst_len = $urandom_range(1, 24);
            for (int k = 0; k < burst_len && rand_count < RANDOM_ITEMS; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    push_item(($urandom_range(0, 1) == 0) ? aaf_pkg::FN_ADD : aaf_pkg::FN_ADC,
                              {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))},
                              1'b0, NO_RES);
                    push_item(aaf_pkg::FN_DAA, 8'($urandom), 1'b0, NO_RES);
                    rand_count += 2;
                end
                else
                begin
                    push_item(aaf_pkg::func_t'($urandom_range(0, 15)), pick_operand(),
                              1'b0, NO_RES);
                    rand_count++;
                end
            end
            if (rand_count >= next_drain)
            begin
                wait_drained();
                next_drain += DRAIN_EVERY;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                idle_cycles($urandom_range(1, 6));
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);

        min_hits = func_hits[0];
        foreach (func_hits[i])
        begin
            if (func_hits[i] < min_hits)
                min_hits = func_hits[i];
        end
        $display("Run covered %0d transfers in and %0d results out over all 16 functions",
                 items_sent, results_checked);
        $display("(fewest uses of any one function: %0d), with %0d mismatches.",
                 min_hits, error_count);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/aaf_pkg.sv
rtl/aaf_in_stage.sv
rtl/aaf_alu.sv
rtl/accumulator_alu_with_flags.sv
rtl/aaf_checker.sv
bench/tb_accumulator_alu_with_flags.sv
